// ===== sv/bzfc_pkg.sv =====
// Shared types and constants for the band z-score fault classifier.
// No dependencies; every other file of the block but bzfc_fifo imports this package.
package bzfc_pkg;

  localparam int NBANDS    = 4;
  localparam int BAND_W    = 2;
  localparam int WORD_W    = 32;
  localparam int SEV_W     = 31;
  localparam int LABEL_W   = 3;
  localparam int CFG_AW    = 5;
  localparam int REG_IDX_W = 3;

  // Register map: means first, then deviations.
  localparam logic [REG_IDX_W-1:0] REG_MEAN_BASE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STD_BASE  = 3'd4;

  localparam logic [WORD_W-1:0] MEAN_RST = 32'd0;
  localparam logic [WORD_W-1:0] STD_RST  = 32'h0001_0000;

  localparam logic [SEV_W-1:0] SEV_MAX = '1;

  // Result labels.
  localparam logic [LABEL_W-1:0] LABEL_NORMAL     = 3'd0;
  localparam logic [LABEL_W-1:0] LABEL_UNBALANCE  = 3'd1;
  localparam logic [LABEL_W-1:0] LABEL_MISALIGN   = 3'd2;
  localparam logic [LABEL_W-1:0] LABEL_OUTER_RACE = 3'd3;
  localparam logic [LABEL_W-1:0] LABEL_INNER_RACE = 3'd4;

  typedef struct packed {
    logic [NBANDS-1:0][WORD_W-1:0] mean;
    logic [NBANDS-1:0][WORD_W-1:0] dev;
  } cfg_t;

  // One prepared item: per band the sign and size of the deviation from the
  // mean, and the divisor after the tiny-deviation substitution.
  typedef struct packed {
    logic [NBANDS-1:0]             neg;
    logic [NBANDS-1:0][WORD_W-1:0] mag;
    logic [NBANDS-1:0][WORD_W-1:0] dvsr;
  } job_t;

  typedef struct packed {
    logic [LABEL_W-1:0] fault_label;
    logic [SEV_W-1:0]   severity;
    logic [NBANDS-1:0]  band_flags;
  } res_t;

  // Fault label that belongs to a band.
  function automatic logic [LABEL_W-1:0] band_label(input logic [BAND_W-1:0] idx);
    logic [LABEL_W-1:0] lbl;
    case (idx)
      2'd0:    lbl = LABEL_UNBALANCE;
      2'd1:    lbl = LABEL_MISALIGN;
      2'd2:    lbl = LABEL_OUTER_RACE;
      2'd3:    lbl = LABEL_INNER_RACE;
      default: lbl = LABEL_NORMAL;
    endcase
    return lbl;
  endfunction

endpackage

// ===== sv/band_zscore_fault_classifier.sv =====
// Top level of the band z-score fault classifier: registers, front end,
// job queue, back end and result queue. Depends on bzfc_pkg, bzfc_regs, bzfc_front, bzfc_fifo, bzfc_back.
//
// Usage:
//   Configuration: APB-style port; mean_band0..3 at byte addresses 0x00..0x0C,
//   std_band0..3 at 0x10..0x1C. Writes land in the access cycle; pready is
//   always high. Write only while no word is in flight.
//   Input: a word of four band energies is taken at an edge with push high and
//   full low. Results: while empty is low the oldest result word is on the
//   out_ ports; it leaves at an edge with pop high.
//   Divider: the back end's pipeline retires one quotient bit per stage in
//   each of four band lanes.
//   Throughput: one word per cycle while the receiver keeps popping.
//   Reset: registers return to mean 0 and deviation 1.0, both queues empty
//   and the pipeline drained.
//   Stalls: when the result queue is full and a finished word waits, the back
//   pipeline holds in place; the four-entry job queue then fills and full rises on the input side.
module band_zscore_fault_classifier #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bzfc_pkg::CFG_AW-1:0]       paddr,
  input  logic [bzfc_pkg::WORD_W-1:0]       pwdata,
  output logic [bzfc_pkg::WORD_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              push,
  output logic                              full,
  input  logic [bzfc_pkg::WORD_W-1:0]       in_energy_band0,
  input  logic [bzfc_pkg::WORD_W-1:0]       in_energy_band1,
  input  logic [bzfc_pkg::WORD_W-1:0]       in_energy_band2,
  input  logic [bzfc_pkg::WORD_W-1:0]       in_energy_band3,
  output logic                              empty,
  input  logic                              pop,
  output logic [bzfc_pkg::LABEL_W-1:0]      out_fault_label,
  output logic [bzfc_pkg::SEV_W-1:0]        out_severity,
  output logic [bzfc_pkg::NBANDS-1:0]       out_band_flags
);
  import bzfc_pkg::*;

  localparam int JOB_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  cfg_t                          cfg;
  logic [NBANDS-1:0][WORD_W-1:0] energy;
  job_t                          job_in;
  job_t                          job_out;
  logic                          job_empty;
  logic                          job_pop;
  res_t                          res_in;
  res_t                          res_out;
  logic                          res_push;
  logic                          res_full;

  assign energy = {in_energy_band3, in_energy_band2, in_energy_band1, in_energy_band0};

  bzfc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bzfc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .energy (energy),
    .cfg    (cfg),
    .job    (job_in)
  );

  // Job queue between front and back ends.
  bzfc_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (job_in),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .full    (full),
    .empty   (job_empty)
  );

  bzfc_back #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue facing the receiver.
  bzfc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_fault_label = res_out.fault_label;
  assign out_severity    = res_out.severity;
  assign out_band_flags  = res_out.band_flags;

endmodule

// ===== sv/bzfc_regs.sv =====
// APB-style register file holding the per-band baseline means and deviations.
// Depends on bzfc_pkg.
module bzfc_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bzfc_pkg::CFG_AW-1:0] paddr,
  input  logic [bzfc_pkg::WORD_W-1:0] pwdata,
  output logic [bzfc_pkg::WORD_W-1:0] prdata,
  output logic                       pready,
  output bzfc_pkg::cfg_t             cfg
);
  import bzfc_pkg::*;

  logic [WORD_W-1:0]    mean_r [NBANDS];
  logic [WORD_W-1:0]    std_r  [NBANDS];
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NBANDS; b++) begin
        mean_r[b] <= MEAN_RST;
        std_r[b]  <= STD_RST;
      end
    end else if (wr_en) begin
      if (idx < REG_STD_BASE) begin
        mean_r[idx[BAND_W-1:0]] <= pwdata;
      end else begin
        std_r[idx[BAND_W-1:0]] <= pwdata;
      end
    end
  end

  // Read-back mux.
  always_comb begin
    if (idx < REG_STD_BASE) begin
      prdata = mean_r[idx[BAND_W-1:0]];
    end else begin
      prdata = std_r[idx[BAND_W-1:0]];
    end
  end

  always_comb begin
    for (int b = 0; b < NBANDS; b++) begin
      cfg.mean[b] = mean_r[b];
      cfg.dev[b]  = std_r[b];
    end
  end

endmodule

// ===== sv/bzfc_front.sv =====
// Front end: turns one input word into a divide job per band (sign, magnitude
// of the deviation from the mean, divisor). Depends on bzfc_pkg.
module bzfc_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic [bzfc_pkg::NBANDS-1:0][bzfc_pkg::WORD_W-1:0] energy,
  input  bzfc_pkg::cfg_t                                   cfg,
  output bzfc_pkg::job_t                                   job
);
  import bzfc_pkg::*;

  // Deviations at or below 0.0001 are replaced by 1.0.
  localparam logic [63:0] ONE_RAW     = 64'(1) << FRAC_BITS;
  localparam logic [63:0] STD_MIN_RAW = ONE_RAW / 10000 + 64'd1;

  always_comb begin
    for (int b = 0; b < NBANDS; b++) begin
      job.neg[b] = energy[b] < cfg.mean[b];
      if (job.neg[b]) begin
        job.mag[b] = cfg.mean[b] - energy[b];
      end else begin
        job.mag[b] = energy[b] - cfg.mean[b];
      end
      if (64'(cfg.dev[b]) < STD_MIN_RAW) begin
        job.dvsr[b] = ONE_RAW[WORD_W-1:0];
      end else begin
        job.dvsr[b] = cfg.dev[b];
      end
    end
  end

endmodule

// ===== sv/bzfc_fifo.sv =====
// Small register-based first-in first-out queue with full and empty flags.
// No package dependencies.
module bzfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    rp_r;
  logic [AW:0]      cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = cnt_r == (AW+1)'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== sv/bzfc_divlane.sv =====
// One band's pipelined restoring divider: (mag << FRAC_BITS) / dvsr, one
// quotient bit per stage, with an early overflow flag. Depends on bzfc_pkg.
module bzfc_divlane #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [bzfc_pkg::WORD_W-1:0]   mag,
  input  logic [bzfc_pkg::WORD_W-1:0]   dvsr,
  output logic [DATA_WIDTH-1:0]         q,
  output logic                          ovf
);
  import bzfc_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int DVW = WORD_W + FRAC_BITS;
  localparam int WW  = DVW + DW;

  logic [WW-1:0]     dext;
  logic [DVW-1:0]    top;
  logic [DW-1:0]     lo;
  logic              ovf0;

  logic [WORD_W-1:0] rem_r [DW];
  logic [WORD_W-1:0] d_r   [DW];
  logic [DW-1:0]     lq_r  [DW+1];
  logic              ovf_r [DW+1];

  // Split the dividend: the part above the quotient width seeds the
  // remainder. A quotient of 2^DW or more shows as that part not below dvsr.
  assign dext = WW'({mag, {FRAC_BITS{1'b0}}});
  assign top  = dext[WW-1:DW];
  assign lo   = dext[DW-1:0];
  assign ovf0 = top >= DVW'(dvsr);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= top[WORD_W-1:0];
      d_r[0]   <= dvsr;
      lq_r[0]  <= lo;
      ovf_r[0] <= ovf0;
    end
  end

  // Each stage brings down one dividend bit and shifts in one quotient bit.
  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    logic            ge;

    assign trial = {rem_r[s], lq_r[s][DW-1]};
    assign diff  = trial - {1'b0, d_r[s]};
    assign ge    = trial >= {1'b0, d_r[s]};

    always_ff @(posedge clk) begin
      if (adv) begin
        lq_r[s+1]  <= {lq_r[s][DW-2:0], ge};
        ovf_r[s+1] <= ovf_r[s];
      end
    end

    if (s < DW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s+1] <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
          d_r[s+1]   <= d_r[s];
        end
      end
    end
  end

  assign q   = lq_r[DW];
  assign ovf = ovf_r[DW];

endmodule

// ===== sv/bzfc_back.sv =====
// Back end: four divider lanes, z-score saturation, per-band flags and the
// argmax that picks label and severity. Depends on bzfc_pkg, bzfc_divlane.
module bzfc_back #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  bzfc_pkg::job_t job,
  output logic           job_pop,
  input  logic           res_full,
  output logic           res_push,
  output bzfc_pkg::res_t res
);
  import bzfc_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam logic [DW-1:0]        ZMAX    = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]        ZMIN    = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [63:0]   THRESH  = 64'(2) << FRAC_BITS;
  localparam logic signed [63:0]   SEV_TOP = 64'(SEV_MAX);

  logic                   adv;
  logic                   v_r   [DW+1];
  logic [NBANDS-1:0]      neg_r [DW+1];
  logic                   va_r;
  logic                   vb_r;

  logic [DW-1:0]          lane_q   [NBANDS];
  logic                   lane_ovf [NBANDS];

  logic signed [DW-1:0]   za_nxt [NBANDS];
  logic signed [DW-1:0]   za_r   [NBANDS];

  logic [NBANDS-1:0]      flag_nxt;
  logic [NBANDS-1:0]      ge_b;
  logic [SEV_W-1:0]       sev_b  [NBANDS];
  logic signed [DW-1:0]   wz_nxt [2];
  logic [BAND_W-1:0]      wi_nxt [2];
  logic                   wg_nxt [2];
  logic [SEV_W-1:0]       ws_nxt [2];

  logic [NBANDS-1:0]      flags_r;
  logic signed [DW-1:0]   wz_r [2];
  logic [BAND_W-1:0]      wi_r [2];
  logic                   wg_r [2];
  logic [SEV_W-1:0]       ws_r [2];

  logic                   sel;

  // The whole pipeline holds while its last word cannot leave.
  assign adv      = !(vb_r && res_full);
  assign job_pop  = adv && job_valid;
  assign res_push = vb_r && !res_full;

  // Valid bits along the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DW; s++) begin
        v_r[s] <= 1'b0;
      end
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= job_valid;
      for (int s = 0; s < DW; s++) begin
        v_r[s+1] <= v_r[s];
      end
      va_r <= v_r[DW];
      vb_r <= va_r;
    end
  end

  // Signs travel alongside the divider stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r[0] <= job.neg;
      for (int s = 0; s < DW; s++) begin
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  for (genvar b = 0; b < NBANDS; b++) begin : g_lane
    bzfc_divlane #(
      .FRAC_BITS  (FRAC_BITS),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_lane (
      .clk  (clk),
      .adv  (adv),
      .mag  (job.mag[b]),
      .dvsr (job.dvsr[b]),
      .q    (lane_q[b]),
      .ovf  (lane_ovf[b])
    );
  end

  // Apply the sign and saturate to the signed z range.
  always_comb begin
    for (int b = 0; b < NBANDS; b++) begin
      if (!neg_r[DW][b]) begin
        za_nxt[b] = (lane_ovf[b] || lane_q[b][DW-1]) ? ZMAX : lane_q[b];
      end else if (lane_ovf[b] || (lane_q[b][DW-1] && |lane_q[b][DW-2:0])) begin
        za_nxt[b] = ZMIN;
      end else begin
        za_nxt[b] = ~lane_q[b] + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int b = 0; b < NBANDS; b++) begin
        za_r[b] <= za_nxt[b];
      end
    end
  end

  // Per-band threshold tests and severity, and the first round of the
  // argmax over band pairs; the lower band wins a tie.
  always_comb begin
    logic signed [63:0] zx;
    for (int b = 0; b < NBANDS; b++) begin
      zx          = 64'(za_r[b]);
      flag_nxt[b] = zx > THRESH;
      ge_b[b]     = zx >= THRESH;
      sev_b[b]    = (zx > SEV_TOP) ? SEV_MAX : zx[SEV_W-1:0];
    end
    for (int p = 0; p < 2; p++) begin
      if (za_r[2*p+1] > za_r[2*p]) begin
        wz_nxt[p] = za_r[2*p+1];
        wi_nxt[p] = BAND_W'(2*p+1);
        wg_nxt[p] = ge_b[2*p+1];
        ws_nxt[p] = sev_b[2*p+1];
      end else begin
        wz_nxt[p] = za_r[2*p];
        wi_nxt[p] = BAND_W'(2*p);
        wg_nxt[p] = ge_b[2*p];
        ws_nxt[p] = sev_b[2*p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags_r <= flag_nxt;
      for (int p = 0; p < 2; p++) begin
        wz_r[p] <= wz_nxt[p];
        wi_r[p] <= wi_nxt[p];
        wg_r[p] <= wg_nxt[p];
        ws_r[p] <= ws_nxt[p];
      end
    end
  end

  // Final round of the argmax and the result word.
  assign sel = wz_r[1] > wz_r[0];

  always_comb begin
    res.band_flags = flags_r;
    if (wg_r[sel]) begin
      res.fault_label = band_label(wi_r[sel]);
      res.severity    = ws_r[sel];
    end else begin
      res.fault_label = LABEL_NORMAL;
      res.severity    = '0;
    end
  end

endmodule

// ===== sv/bzfc_checker.sv =====
// Port-level checks on the classifier's result channel, bound to the top level.
// Depends on bzfc_pkg and band_zscore_fault_classifier.
module bzfc_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         empty,
  input logic                         pop,
  input logic [bzfc_pkg::LABEL_W-1:0] out_fault_label,
  input logic [bzfc_pkg::SEV_W-1:0]   out_severity,
  input logic [bzfc_pkg::NBANDS-1:0]  out_band_flags
);
  import bzfc_pkg::*;

  localparam logic [63:0] SEV_FLOOR = 64'(2) << FRAC_BITS;

  // A waiting result word holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_fault_label) && $stable(out_severity)
      && $stable(out_band_flags))
    else $error("result word changed while waiting");

  // Normal results carry zero severity; labels stay in the defined set.
  a_normal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_fault_label == LABEL_NORMAL |-> out_severity == '0)
    else $error("normal label with nonzero severity");

  a_label: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_fault_label <= LABEL_INNER_RACE)
    else $error("label out of range");

  // A fault means the winning z-score reached the 2.0 threshold.
  a_sev: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_fault_label != LABEL_NORMAL |-> 64'(out_severity) >= SEV_FLOOR)
    else $error("fault severity below threshold");

  // Any band above threshold forces a fault label.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_band_flags != '0 |-> out_fault_label != LABEL_NORMAL)
    else $error("band flag set on a normal result");

endmodule

bind band_zscore_fault_classifier bzfc_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_bzfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_fault_label (out_fault_label),
  .out_severity    (out_severity),
  .out_band_flags  (out_band_flags)
);
